>>> rtl/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
package ffsa_pkg;

    localparam int OFFSET_BITS      = 16;
    localparam int LEN_BITS         = OFFSET_BITS + 1;
    localparam int MAX_SEGMENTS_DEF = 16;

    localparam logic [LEN_BITS-1:0] POOL_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        OP_HOLD       = 6'b000001,
        OP_SRCH_ALLOC = 6'b000010,
        OP_SRCH_FREE  = 6'b000100,
        OP_ALLOC      = 6'b001000,
        OP_FREE       = 6'b010000,
        OP_MERGE      = 6'b100000
    } t_op;

    typedef struct packed {
        logic                   valid;
        logic                   free;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    len;
    } t_seg;

    typedef struct packed {
        t_op                    op;
        logic [LEN_BITS-1:0]    size;
        logic [OFFSET_BITS-1:0] offset;
        logic                   split;
        logic                   mark;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic sel;
    } t_link;

    typedef struct packed {
        logic                   exact;
        logic [OFFSET_BITS-1:0] grant;
    } t_res;

endpackage

>>> rtl/ffsa_cell.sv
// One segment slot of the table: holds a segment and shifts with its neighbors.
module ffsa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffsa_pkg::t_cmd i_cmd,
    input  logic           i_init,
    input  ffsa_pkg::t_seg i_init_seg,
    input  ffsa_pkg::t_seg i_left_seg,
    input  ffsa_pkg::t_seg i_right_seg,
    input  ffsa_pkg::t_link i_link,
    output ffsa_pkg::t_seg o_seg,
    output ffsa_pkg::t_link o_link,
    output ffsa_pkg::t_res o_res
);
    import ffsa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;
    logic r_hit;
    logic n_hit;
    logic hit;
    logic sel;

    always_comb begin
        if (i_cmd.op == OP_MERGE) begin
            hit = r_seg.valid & r_seg.free & i_right_seg.valid & i_right_seg.free;
        end else begin
            hit = r_hit;
        end
        sel          = hit & ~i_link.found;
        o_link.found = i_link.found | hit;
        o_link.sel   = sel;
        o_res.exact  = sel & (r_seg.len == i_cmd.size);
        o_res.grant  = sel ? r_seg.start : '0;
    end

    always_comb begin
        n_hit = r_hit;
        n_seg = r_seg;
        case (i_cmd.op)
            OP_SRCH_ALLOC: begin
                n_hit = r_seg.valid & r_seg.free & (r_seg.len >= i_cmd.size);
            end
            OP_SRCH_FREE: begin
                n_hit = r_seg.valid & (r_seg.start == i_cmd.offset);
            end
            OP_ALLOC: begin
                if (sel) begin
                    if (i_cmd.mark) begin
                        n_seg.free = 1'b0;
                    end
                    if (i_cmd.split) begin
                        n_seg.len = i_cmd.size;
                    end
                end else if (i_link.sel && i_cmd.split) begin
                    // remainder of the split segment
                    n_seg.valid = 1'b1;
                    n_seg.free  = 1'b1;
                    n_seg.start = i_left_seg.start + i_cmd.size[OFFSET_BITS-1:0];
                    n_seg.len   = i_left_seg.len - i_cmd.size;
                end else if (i_link.found && i_cmd.split) begin
                    n_seg = i_left_seg;
                end
            end
            OP_FREE: begin
                if (sel) begin
                    n_seg.free = 1'b1;
                end
            end
            OP_MERGE: begin
                if (sel) begin
                    n_seg.len = r_seg.len + i_right_seg.len;
                end else if (i_link.found) begin
                    n_seg = i_right_seg;
                end
            end
            default: begin
                n_seg = r_seg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_seg <= i_init_seg;
        end else begin
            r_seg <= n_seg;
        end
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_seg = r_seg;

endmodule

>>> rtl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: sequencer and segment cell row.
//
// After acceptance, a request passes through a search step and an apply step, then
// a done step that loads the output register. An allocate, or a free whose offset
// is not found, goes from the apply step straight to the done step. A free that finds
// its segment first runs merge passes (one pass per adjacent free pair, plus a final
// pass that finds none) and then the done step. The cell row applies one table change
// per cycle. The next request is taken in the cycle after the previous one has reached
// the output register. While a result waits in the output register, the next request
// runs up to its last step and holds there.
// A pool size write rebuilds the table to one free segment in the same cycle.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ffsa_pkg::LEN_BITS-1:0]      i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_func,
    input  logic [ffsa_pkg::LEN_BITS-1:0]      i_request_size,
    input  logic [ffsa_pkg::OFFSET_BITS-1:0]   i_release_offset,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ffsa_pkg::OFFSET_BITS-1:0]   o_granted_offset,
    output logic [1:0]                         o_status
);
    import ffsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_ACT    = 5'b00100,
        S_MERGE  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                   r_func;
    logic [LEN_BITS-1:0]    r_size;
    logic [OFFSET_BITS-1:0] r_off;
    logic [OFFSET_BITS-1:0] r_grant;
    logic [OFFSET_BITS-1:0] n_grant;
    t_status                r_stat;
    t_status                n_stat;
    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_out_grant;
    t_status                r_out_stat;

    t_cmd  cmd;
    t_seg  w_seg [MAX_SEGMENTS];
    t_link w_link [MAX_SEGMENTS+1];
    t_res  w_res [MAX_SEGMENTS];
    logic  any_hit;
    logic  any_exact;
    logic  full;
    logic [OFFSET_BITS-1:0] hit_start;
    logic  init;
    logic [LEN_BITS-1:0] init_len;
    t_seg  head_init;

    assign init     = i_cfg_we;
    assign init_len = !i_rst_n ? POOL_LIMIT :
                      ((i_cfg_data > POOL_LIMIT) ? POOL_LIMIT : i_cfg_data);

    always_comb begin
        head_init       = '0;
        head_init.valid = 1'b1;
        head_init.free  = 1'b1;
        head_init.len   = init_len;
    end

    assign w_link[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            t_seg left_seg;
            t_seg right_seg;
            t_seg init_seg;
            if (g == 0) begin : g_head
                assign left_seg = '0;
                assign init_seg = head_init;
            end else begin : g_body
                assign left_seg = w_seg[g-1];
                assign init_seg = '0;
            end
            if (g == MAX_SEGMENTS - 1) begin : g_tail
                assign right_seg = '0;
            end else begin : g_inner
                assign right_seg = w_seg[g+1];
            end
            ffsa_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_init      (init),
                .i_init_seg  (init_seg),
                .i_left_seg  (left_seg),
                .i_right_seg (right_seg),
                .i_link      (w_link[g]),
                .o_seg       (w_seg[g]),
                .o_link      (w_link[g+1]),
                .o_res       (w_res[g])
            );
        end
    endgenerate

    always_comb begin
        any_exact = 1'b0;
        hit_start = '0;
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            any_exact = any_exact | w_res[k].exact;
            hit_start = hit_start | w_res[k].grant;
        end
        any_hit = w_link[MAX_SEGMENTS].found;
        full    = w_seg[MAX_SEGMENTS-1].valid;
    end

    always_comb begin
        n_state    = r_state;
        n_grant    = r_grant;
        n_stat     = r_stat;
        cmd        = '0;
        cmd.op     = OP_HOLD;
        cmd.size   = r_size;
        cmd.offset = r_off;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.op  = (r_func == FUNC_FREE) ? OP_SRCH_FREE : OP_SRCH_ALLOC;
                n_state = S_ACT;
            end
            S_ACT: begin
                n_grant = '0;
                if (r_func == FUNC_FREE) begin
                    cmd.op = OP_FREE;
                    if (any_hit) begin
                        n_stat  = ST_OK;
                        n_state = S_MERGE;
                    end else begin
                        n_stat  = ST_NOTFOUND;
                        n_state = S_DONE;
                    end
                end else begin
                    cmd.op  = OP_ALLOC;
                    n_state = S_DONE;
                    if (r_size == '0 || !any_hit) begin
                        n_stat = ST_NOFIT;
                    end else if (any_exact) begin
                        cmd.mark = 1'b1;
                        n_stat   = ST_OK;
                        n_grant  = hit_start;
                    end else if (full) begin
                        n_stat = ST_FULL;
                    end else begin
                        cmd.mark  = 1'b1;
                        cmd.split = 1'b1;
                        n_stat    = ST_OK;
                        n_grant   = hit_start;
                    end
                end
            end
            S_MERGE: begin
                cmd.op = OP_MERGE;
                if (!any_hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_grant <= n_grant;
        r_stat  <= n_stat;
        if (r_state == S_IDLE && i_valid) begin
            r_func <= i_func;
            r_size <= i_request_size;
            r_off  <= i_release_offset;
        end
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out_grant <= r_grant;
            r_out_stat  <= r_stat;
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_granted_offset = r_out_grant;
    assign o_status         = r_out_stat;

endmodule
